// ----- hdl/fsbm_pkg.sv -----
package fsbm_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD_TMPL = 2'd0,
    MODE_LOAD_WIN  = 2'd1,
    MODE_SEARCH    = 2'd2,
    MODE_REPORT    = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_EMIT,
    ST_DIV,
    ST_REPORT
  } state_t;

  localparam logic [0:0] REG_BLOCK_SIZE   = 1'b0;
  localparam logic [0:0] REG_ERROR_METRIC = 1'b1;

  localparam int ERR_BITS   = 25;
  localparam int OUT_BITS   = 24;
  localparam int SUM_BITS   = 40;
  localparam int COUNT_BITS = 16;
  localparam int DIV_STEPS  = 42;

  typedef struct packed {
    logic search_init;   // clear best, reset walk counters
    logic walk_step;     // issue one pixel pair read
    logic accumulate;    // fold result into frame sum
    logic div_init;      // load divider
    logic div_step;      // one restoring step
    logic clear_frame;   // clear sum and count
  } ctrl_t;

  typedef struct packed {
    logic walk_done;     // last pixel pair issued
    logic pipe_empty;    // no reads in flight
    logic div_done;
    logic count_zero;
  } status_t;

endpackage

// ----- hdl/fsbm_ctrl.sv -----
module fsbm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             go_search,
  input  logic             go_report,
  input  fsbm_pkg::status_t status,
  output fsbm_pkg::ctrl_t   ctrl,
  output logic             busy,
  output logic             emit_search,
  output logic             emit_report
);

  fsbm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsbm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fsbm_pkg::ST_IDLE: begin
        if (go_search) begin
          state_next = fsbm_pkg::ST_SEARCH;
        end else if (go_report) begin
          state_next = status.count_zero ? fsbm_pkg::ST_REPORT : fsbm_pkg::ST_DIV;
        end
      end
      fsbm_pkg::ST_SEARCH: if (status.walk_done) state_next = fsbm_pkg::ST_DRAIN;
      fsbm_pkg::ST_DRAIN:  if (status.pipe_empty) state_next = fsbm_pkg::ST_EMIT;
      fsbm_pkg::ST_EMIT:   state_next = fsbm_pkg::ST_IDLE;
      fsbm_pkg::ST_DIV:    if (status.div_done) state_next = fsbm_pkg::ST_REPORT;
      fsbm_pkg::ST_REPORT: state_next = fsbm_pkg::ST_IDLE;
      default:             state_next = fsbm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl        = '0;
    busy        = 1'b1;
    emit_search = 1'b0;
    emit_report = 1'b0;
    case (state)
      fsbm_pkg::ST_IDLE: begin
        busy             = 1'b0;
        ctrl.search_init = go_search;
        ctrl.div_init    = go_report;
      end
      fsbm_pkg::ST_SEARCH: ctrl.walk_step = 1'b1;
      fsbm_pkg::ST_DRAIN:  ;
      fsbm_pkg::ST_EMIT: begin
        ctrl.accumulate = 1'b1;
        emit_search     = 1'b1;
      end
      fsbm_pkg::ST_DIV:    ctrl.div_step = 1'b1;
      fsbm_pkg::ST_REPORT: begin
        ctrl.clear_frame = 1'b1;
        emit_report      = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/fsbm_datapath.sv -----
module fsbm_datapath #(
  parameter int BLOCK_MAX  = 16,
  parameter int PIXEL_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load_tmpl,
  input  logic                     load_win,
  input  logic [5:0]               row,
  input  logic [5:0]               col,
  input  logic [7:0]               pixel,
  input  logic [$clog2(BLOCK_MAX):0] nb,
  input  logic                     metric_sq,
  input  fsbm_pkg::ctrl_t          ctrl,
  output fsbm_pkg::status_t        status,
  output logic [23:0]              min_sad,
  output logic [5:0]               vec_row,
  output logic [5:0]               vec_col,
  output logic [23:0]              average,
  output logic                     average_valid
);

  localparam int WIN_MAX = 3 * BLOCK_MAX;
  localparam int BW      = $clog2(BLOCK_MAX);
  localparam int WW      = $clog2(WIN_MAX);
  localparam int DW      = BW + 2;
  localparam int TDEPTH  = BLOCK_MAX * BLOCK_MAX;
  localparam int WDEPTH  = WIN_MAX * WIN_MAX;
  localparam int TAW     = $clog2(TDEPTH);
  localparam int WAW     = $clog2(WDEPTH);
  localparam int EB      = fsbm_pkg::ERR_BITS;
  localparam int SB      = fsbm_pkg::SUM_BITS;
  localparam int CB      = fsbm_pkg::COUNT_BITS;
  localparam int QB      = SB + 2;

  logic [PIXEL_BITS-1:0] tmem [TDEPTH];
  logic [PIXEL_BITS-1:0] wmem [WDEPTH];

  // load addressing
  logic [TAW-1:0] t_waddr;
  logic [WAW-1:0] w_waddr;
  assign t_waddr = TAW'(row[BW-1:0] * BLOCK_MAX + col[BW-1:0]);
  assign w_waddr = WAW'(32'(row) * WIN_MAX + 32'(col));
  logic t_inb, w_inb;
  assign t_inb = (32'(row) < BLOCK_MAX) && (32'(col) < BLOCK_MAX);
  assign w_inb = (32'(row) < WIN_MAX) && (32'(col) < WIN_MAX);

  // walk counters: dc outer, dr, then r, c inner
  logic [DW-1:0] dc, dr;   // offset + nb, 0..2nb
  logic [BW-1:0] r, c;
  logic [DW-1:0] two_nb;
  logic [BW-1:0] nb_m1;
  assign two_nb = DW'({nb, 1'b0});
  assign nb_m1  = BW'(nb - 1'b1);

  logic last_c, last_r, last_dr, last_dc;
  assign last_c  = (c == nb_m1);
  assign last_r  = (r == nb_m1);
  assign last_dr = (dr == two_nb);
  assign last_dc = (dc == two_nb);

  logic [WW-1:0] wr, wc;
  assign wr = WW'(dr + r);
  assign wc = WW'(dc + c);

  always_ff @(posedge clk) begin
    if (load_tmpl && t_inb) tmem[t_waddr] <= PIXEL_BITS'(pixel);
    if (load_win && w_inb)  wmem[w_waddr] <= PIXEL_BITS'(pixel);
  end

  logic [PIXEL_BITS-1:0] t_q, w_q;
  logic s1_v, s1_first, s1_last;
  logic [DW-1:0] s1_dr, s1_dc;
  always_ff @(posedge clk) begin
    t_q      <= tmem[TAW'(r * BLOCK_MAX + c)];
    w_q      <= wmem[WAW'(wr * WIN_MAX + wc)];
    s1_first <= (r == '0) && (c == '0);
    s1_last  <= last_r && last_c;
    s1_dr    <= dr;
    s1_dc    <= dc;
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.search_init) begin
      dc <= '0; dr <= '0; r <= '0; c <= '0;
    end else if (ctrl.walk_step) begin
      c <= last_c ? '0 : c + 1'b1;
      if (last_c) begin
        r <= last_r ? '0 : r + 1'b1;
        if (last_r) begin
          dr <= last_dr ? '0 : dr + 1'b1;
          if (last_dr) dc <= dc + 1'b1;
        end
      end
    end
  end
  assign status.walk_done = ctrl.walk_step && last_c && last_r && last_dr && last_dc;

  // stage 2: pixel error
  logic [PIXEL_BITS-1:0] diff;
  assign diff = (t_q > w_q) ? t_q - w_q : w_q - t_q;
  logic [2*PIXEL_BITS-1:0] perr;
  logic s2_v, s2_first, s2_last;
  logic [DW-1:0] s2_dr, s2_dc;
  always_ff @(posedge clk) begin
    perr     <= metric_sq ? diff * diff : (2*PIXEL_BITS)'(diff);
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_dr    <= s1_dr;
    s2_dc    <= s1_dc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0;
    end else begin
      s1_v <= ctrl.walk_step;
      s2_v <= s1_v;
    end
  end

  // stage 3: block accumulation with saturation, then compare
  logic [EB-1:0] acc;
  logic [EB:0]   acc_sum;
  logic [EB-1:0] acc_new;
  assign acc_sum = {1'b0, s2_first ? '0 : acc} + (EB+1)'(perr);
  assign acc_new = acc_sum[EB] ? '1 : acc_sum[EB-1:0];

  logic [EB-1:0] best;
  logic [DW-1:0] best_dr, best_dc;
  always_ff @(posedge clk) begin
    if (rst || ctrl.search_init) begin
      best    <= '1;
      best_dr <= '0;
      best_dc <= '0;
    end else if (s2_v) begin
      acc <= acc_new;
      if (s2_last && acc_new < best) begin
        best    <= acc_new;
        best_dr <= s2_dr;
        best_dc <= s2_dc;
      end
    end
  end
  assign status.pipe_empty = !s1_v && !s2_v;

  logic [23:0] best_sat;
  assign best_sat = (best > EB'(24'hFFFFFF)) ? 24'hFFFFFF : best[23:0];
  assign min_sad  = best_sat;
  assign vec_row  = 6'(32'(best_dr) - 32'(nb));
  assign vec_col  = 6'(32'(best_dc) - 32'(nb));

  // frame totals
  logic [SB-1:0] fsum;
  logic [CB-1:0] fcnt;
  logic [SB:0]   fsum_add;
  assign fsum_add = {1'b0, fsum} + (SB+1)'(best_sat);
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear_frame) begin
      fsum <= '0;
      fcnt <= '0;
    end else if (ctrl.accumulate) begin
      fsum <= fsum_add[SB] ? '1 : fsum_add[SB-1:0];
      if (fcnt != '1) fcnt <= fcnt + 1'b1;
    end
  end
  assign status.count_zero = (fcnt == '0);

  // restoring divide: (2*sum + n) / (2*n)
  logic [QB-1:0] quo;
  logic [CB+1:0] rem;
  logic [CB:0]   dvs;
  logic [6:0]    dcnt;
  logic [CB+1:0] rem_sh;
  assign rem_sh = {rem[CB:0], quo[QB-1]};
  always_ff @(posedge clk) begin
    if (ctrl.div_init) begin
      quo  <= QB'({fsum, 1'b0}) + QB'(fcnt);
      rem  <= '0;
      dvs  <= {fcnt, 1'b0};
      dcnt <= '0;
    end else if (ctrl.div_step) begin
      dcnt <= dcnt + 1'b1;
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= rem_sh - {1'b0, dvs};
        quo <= {quo[QB-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[QB-2:0], 1'b0};
      end
    end
  end
  assign status.div_done = ctrl.div_step && (dcnt == 7'(fsbm_pkg::DIV_STEPS - 1));

  assign average_valid = !status.count_zero;
  assign average = status.count_zero ? 24'd0 :
                   (|quo[QB-1:24]) ? 24'hFFFFFF : quo[23:0];

endmodule

// ----- hdl/full_search_block_matcher_core.sv -----
// Load items (template/window pixel) are written when taken; busy stays low.
// Search: the walk issues one pixel pair read per cycle from the window memory,
// then drains the pipeline before the done strobe.
// Report: runs through a bit-serial divider, skipped with no blocks counted.
// Results appear for one cycle on done; the receiver cannot stall.
// Synchronous reset clears control and frame totals and sets config to its defaults; stores stay undefined.
module full_search_block_matcher_core #(
  parameter int BLOCK_MAX  = 16,
  parameter int PIXEL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [5:0]  row,
  input  logic [5:0]  col,
  input  logic [7:0]  pixel,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output logic        done,
  output logic        result_kind,
  output logic [23:0] min_sad,
  output logic signed [5:0] vec_row,
  output logic signed [5:0] vec_col,
  output logic [23:0] average,
  output logic        average_valid
);

  localparam int NW = $clog2(BLOCK_MAX) + 1;

  logic [4:0] block_size;
  logic       error_metric;
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size   <= 5'd16;
      error_metric <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fsbm_pkg::REG_BLOCK_SIZE:   block_size   <= cfg_data;
        fsbm_pkg::REG_ERROR_METRIC: error_metric <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] nb;
  assign nb = (block_size == 5'd0) ? NW'(1) :
              (32'(block_size) > BLOCK_MAX) ? NW'(BLOCK_MAX) : NW'(block_size);

  logic take;
  assign take = start && !busy;

  fsbm_pkg::ctrl_t   ctrl;
  fsbm_pkg::status_t status;
  logic emit_search, emit_report;

  fsbm_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .go_search(take && mode == fsbm_pkg::MODE_SEARCH),
    .go_report(take && mode == fsbm_pkg::MODE_REPORT),
    .status(status), .ctrl(ctrl), .busy(busy),
    .emit_search(emit_search), .emit_report(emit_report)
  );

  logic [23:0] d_sad, d_avg;
  logic [5:0]  d_vr, d_vc;
  logic        d_av;

  fsbm_datapath #(.BLOCK_MAX(BLOCK_MAX), .PIXEL_BITS(PIXEL_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .load_tmpl(take && mode == fsbm_pkg::MODE_LOAD_TMPL),
    .load_win(take && mode == fsbm_pkg::MODE_LOAD_WIN),
    .row(row), .col(col), .pixel(pixel), .nb(nb), .metric_sq(error_metric),
    .ctrl(ctrl), .status(status),
    .min_sad(d_sad), .vec_row(d_vr), .vec_col(d_vc),
    .average(d_avg), .average_valid(d_av)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= emit_search || emit_report;
    end
    result_kind   <= emit_report;
    min_sad       <= emit_search ? d_sad : 24'd0;
    vec_row       <= emit_search ? d_vr : 6'd0;
    vec_col       <= emit_search ? d_vc : 6'd0;
    average       <= emit_report ? d_avg : 24'd0;
    average_valid <= emit_report && d_av;
  end

`ifndef ASSERT_OFF
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without busy");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == fsbm_pkg::MODE_SEARCH || mode == fsbm_pkg::MODE_REPORT))
      |=> busy) else $error("request not held busy");
  a_report_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result_kind) |-> (min_sad == 24'd0)) else $error("report carries sad");
`endif

endmodule

// ----- tb/sv/tb_full_search_block_matcher_core.sv -----
module tb_full_search_block_matcher_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BMAX = 16;
  localparam int WMAX = 3 * BMAX;
  localparam int STALL_LIMIT = 1000000;

  typedef struct {
    logic        kind;
    logic [23:0] sad;
    logic [5:0]  vr;
    logic [5:0]  vc;
    logic [23:0] avg;
    logic        avg_ok;
  } match_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  fsbm_pkg::mode_t mode;
  logic [5:0]  row;
  logic [5:0]  col;
  logic [7:0]  pixel;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [4:0]  cfg_data;
  logic        done;
  logic        result_kind;
  logic [23:0] min_sad;
  logic signed [5:0] vec_row;
  logic signed [5:0] vec_col;
  logic [23:0] average;
  logic        average_valid;

  full_search_block_matcher_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .row(row),
    .col(col), .pixel(pixel), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .result_kind(result_kind),
    .min_sad(min_sad), .vec_row(vec_row), .vec_col(vec_col),
    .average(average), .average_valid(average_valid)
  );

  // Shadow of the block
  logic [7:0]  tmpl_px [BMAX][BMAX];
  logic [7:0]  win_px [WMAX][WMAX];
  logic [39:0] frame_sum;
  logic [15:0] frame_blocks;
  logic [4:0]  size_reg;
  logic        metric_reg;

  match_result_t pending_results[$];
  int  errors;
  int  stall_cycles;
  bit  steady;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int eff_size();
    if (size_reg == 0) return 1;
    if (size_reg > BMAX) return BMAX;
    return int'(size_reg);
  endfunction

  function automatic void predict_search();
    int nb;
    int dr;
    int dc;
    int r;
    int c;
    int d;
    longint e;
    longint best;
    longint m;
    int br;
    int bc;
    match_result_t res;
    nb = eff_size();
    best = 64'h1FFFFFF;
    br = -nb;
    bc = -nb;
    for (dc = -nb; dc <= nb; dc++) begin
      for (dr = -nb; dr <= nb; dr++) begin
        e = 0;
        for (r = 0; r < nb; r++) begin
          for (c = 0; c < nb; c++) begin
            d = int'(tmpl_px[r][c]) - int'(win_px[nb + dr + r][nb + dc + c]);
            if (d < 0) d = -d;
            e += metric_reg ? d * d : d;
            if (e > 64'h1FFFFFF) e = 64'h1FFFFFF;
          end
        end
        if (e < best) begin
          best = e;
          br = dr;
          bc = dc;
        end
      end
    end
    m = (best > 64'hFFFFFF) ? 64'hFFFFFF : best;
    if (longint'(frame_sum) + m > 64'hFF_FFFF_FFFF) frame_sum = 40'hFF_FFFF_FFFF;
    else frame_sum = frame_sum + 40'(m);
    if (frame_blocks != 16'hFFFF) frame_blocks++;
    res.kind = 1'b0;
    res.sad = 24'(m);
    res.vr = 6'(br);
    res.vc = 6'(bc);
    res.avg = '0;
    res.avg_ok = 1'b0;
    pending_results.push_back(res);
  endfunction

  function automatic void predict_report();
    longint n;
    longint a;
    match_result_t res;
    res.kind = 1'b1;
    res.sad = '0;
    res.vr = '0;
    res.vc = '0;
    res.avg = '0;
    res.avg_ok = 1'b0;
    if (frame_blocks != 0) begin
      n = frame_blocks;
      a = (2 * longint'(frame_sum) + n) / (2 * n);
      res.avg = (a > 64'hFFFFFF) ? 24'hFFFFFF : 24'(a);
      res.avg_ok = 1'b1;
    end
    frame_sum = '0;
    frame_blocks = '0;
    pending_results.push_back(res);
  endfunction

  task automatic send_request(fsbm_pkg::mode_t m, logic [5:0] r, logic [5:0] c,
                              logic [7:0] p);
    while (!steady && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    row <= r;
    col <= c;
    pixel <= p;
    do @(posedge clk); while (busy);
    case (m)
      fsbm_pkg::MODE_LOAD_TMPL: if (r < BMAX && c < BMAX) tmpl_px[r][c] = p;
      fsbm_pkg::MODE_LOAD_WIN:  if (r < WMAX && c < WMAX) win_px[r][c] = p;
      fsbm_pkg::MODE_SEARCH:    predict_search();
      fsbm_pkg::MODE_REPORT:    predict_report();
      default: ;
    endcase
  endtask

  // Hold off until every expected result has come, then let a load settle
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [4:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == fsbm_pkg::REG_BLOCK_SIZE) size_reg = val;
    else metric_reg = val[0];
  endtask

  // Fill the template and window area that an nb by nb block touches
  task automatic load_all(int nb);
    int r;
    int c;
    steady = 1'b1;
    for (r = 0; r < nb; r++)
      for (c = 0; c < nb; c++)
        send_request(fsbm_pkg::MODE_LOAD_TMPL, 6'(r), 6'(c), 8'($urandom));
    for (r = 0; r < 3 * nb; r++)
      for (c = 0; c < 3 * nb; c++)
        send_request(fsbm_pkg::MODE_LOAD_WIN, 6'(r), 6'(c), 8'($urandom));
    steady = 1'b0;
  endtask

  task automatic test_empty_report();
    send_request(fsbm_pkg::MODE_REPORT, 6'($urandom), 6'($urandom), 8'($urandom));
  endtask

  // Back-to-back loads with no idling over the area the random searches use
  task automatic test_fill_stores();
    load_all(8);
  endtask

  // Flat picture: all offsets tie, the first wins; then 1x1 search, report
  task automatic test_ties_and_extremes();
    int r;
    int c;
    write_cfg(fsbm_pkg::REG_BLOCK_SIZE, 5'd2);
    write_cfg(fsbm_pkg::REG_ERROR_METRIC, 5'd0);
    for (r = 0; r < 2; r++)
      for (c = 0; c < 2; c++)
        send_request(fsbm_pkg::MODE_LOAD_TMPL, 6'(r), 6'(c), 8'd0);
    for (r = 0; r < 6; r++)
      for (c = 0; c < 6; c++)
        send_request(fsbm_pkg::MODE_LOAD_WIN, 6'(r), 6'(c), 8'd0);
    send_request(fsbm_pkg::MODE_SEARCH, 6'd0, 6'd0, 8'd0);
    send_request(fsbm_pkg::MODE_LOAD_TMPL, 6'd63, 6'd63, 8'hFF);
    send_request(fsbm_pkg::MODE_LOAD_WIN, 6'd48, 6'd0, 8'hFF);
    send_request(fsbm_pkg::MODE_LOAD_WIN, 6'd0, 6'd63, 8'hFF);
    send_request(fsbm_pkg::MODE_LOAD_TMPL, 6'd1, 6'd1, 8'hFF);
    write_cfg(fsbm_pkg::REG_BLOCK_SIZE, 5'd0);
    send_request(fsbm_pkg::MODE_SEARCH, 6'd0, 6'd0, 8'd0);
    send_request(fsbm_pkg::MODE_REPORT, 6'd0, 6'd0, 8'd0);
  endtask

  task automatic random_phase(int bs, bit met, int items, int searches);
    int i;
    int k;
    int nb;
    int sel;
    int gap;
    write_cfg(fsbm_pkg::REG_BLOCK_SIZE, 5'(bs));
    write_cfg(fsbm_pkg::REG_ERROR_METRIC, 5'(met));
    nb = eff_size();
    gap = items / searches;
    steady = ($urandom_range(3) == 0);
    for (i = 0; i < items; i++) begin
      sel = $urandom_range(99);
      if (i % gap == gap - 1) begin
        send_request(fsbm_pkg::MODE_SEARCH, 6'($urandom), 6'($urandom), 8'($urandom));
      end else if (sel < 3) begin
        send_request(fsbm_pkg::MODE_REPORT, 6'($urandom), 6'($urandom), 8'($urandom));
      end else if (sel < 12) begin
        // out-of-store load, dropped by the block
        k = $urandom_range(1);
        send_request(k ? fsbm_pkg::MODE_LOAD_WIN : fsbm_pkg::MODE_LOAD_TMPL,
                     6'($urandom_range(48, 63)), 6'($urandom), 8'($urandom));
      end else if (sel < 40) begin
        send_request(fsbm_pkg::MODE_LOAD_TMPL, 6'($urandom_range(nb - 1)),
                     6'($urandom_range(nb - 1)), 8'($urandom));
      end else begin
        send_request(fsbm_pkg::MODE_LOAD_WIN, 6'($urandom_range(3 * nb - 1)),
                     6'($urandom_range(3 * nb - 1)), 8'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_random();
    random_phase(1, 1'b0, 50, 5);
    random_phase(2, 1'b1, 50, 5);
    random_phase(3, 1'b0, 50, 4);
    random_phase(4, 1'b1, 60, 4);
    random_phase(5, 1'b0, 50, 3);
    random_phase(8, 1'b1, 50, 2);
    random_phase(3, 1'b1, 50, 4);
    random_phase(0, 1'b1, 40, 4);
    random_phase(2, 1'b0, 50, 5);
    random_phase(1, 1'b1, 50, 5);
    send_request(fsbm_pkg::MODE_REPORT, 6'd0, 6'd0, 8'd0);
  endtask

  always @(posedge clk) begin
    match_result_t exp_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result kind=%0d", result_kind);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (result_kind !== exp_res.kind) begin
          $error("result_kind exp %0d got %0d", exp_res.kind, result_kind);
          errors++;
        end
        if (min_sad !== exp_res.sad) begin
          $error("min_sad exp %0d got %0d", exp_res.sad, min_sad);
          errors++;
        end
        if (vec_row !== exp_res.vr) begin
          $error("vec_row exp %0d got %0d", $signed(exp_res.vr), vec_row);
          errors++;
        end
        if (vec_col !== exp_res.vc) begin
          $error("vec_col exp %0d got %0d", $signed(exp_res.vc), vec_col);
          errors++;
        end
        if (average !== exp_res.avg) begin
          $error("average exp %0d got %0d", exp_res.avg, average);
          errors++;
        end
        if (average_valid !== exp_res.avg_ok) begin
          $error("average_valid exp %0d got %0d", exp_res.avg_ok, average_valid);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    steady = 1'b0;
    frame_sum = '0;
    frame_blocks = '0;
    size_reg = 5'd16;
    metric_reg = 1'b0;
    rst <= 1'b1;
    start <= 1'b0;
    mode <= fsbm_pkg::MODE_LOAD_TMPL;
    row <= '0;
    col <= '0;
    pixel <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_report();
    test_ties_and_extremes();
    test_fill_stores();
    test_random();
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- full_search_block_matcher_core.f -----
hdl/fsbm_pkg.sv
hdl/fsbm_ctrl.sv
hdl/fsbm_datapath.sv
hdl/full_search_block_matcher_core.sv
tb/sv/tb_full_search_block_matcher_core.sv
